### rtl/armrel_pkg.sv
`default_nettype none

package armrel_pkg;

	// relocation types handled
	localparam logic [7:0] CMD_ABS32 = 8'd2;
	localparam logic [7:0] CMD_CALL  = 8'd28;
	localparam logic [7:0] CMD_JMP24 = 8'd29;
	localparam logic [7:0] CMD_MOVW  = 8'd43;
	localparam logic [7:0] CMD_MOVT  = 8'd44;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH = 1'd1;

	localparam int unsigned PLT_ENTRIES_DEF = 128;
	localparam int unsigned PLT_SLOT_BYTES  = 12;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [31:0] BRANCH_KEEP_MASK = 32'hFF00_0000;
	localparam logic [31:0] MOV_KEEP_MASK    = 32'hFFF0_F000;
	localparam logic [31:0] MOV_LOW_MASK     = 32'h0000_0FFF;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_OFFSET = 3'd1,
		ST_PLT_ADDEND = 3'd2,
		ST_RANGE      = 3'd3,
		ST_UNKNOWN    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		KIND_ABS32,
		KIND_BRANCH,
		KIND_MOVW,
		KIND_MOVT,
		KIND_NONE
	} kind_t;

	// classified relocation handed from front to back
	typedef struct packed {
		kind_t       kind;
		status_t     status;   // early verdict; ST_OK lets the back decide
		logic [31:0] old_word;
		logic [31:0] opa;      // branch target, or symbol address
		logic [31:0] opb;      // branch field, old word for ABS32, else 0
		logic [31:0] opc;      // place address for branches, else 0
		logic [31:0] addend;
	} item_t;

endpackage

`default_nettype wire

### rtl/armrel_front.sv
`default_nettype none

module armrel_front #(
	parameter int unsigned PLT_ENTRIES = armrel_pkg::PLT_ENTRIES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [armrel_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                       cfg_data,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic [7:0]                        command,
	input  wire logic [31:0]                       old_word,
	input  wire logic [31:0]                       symbol_address,
	input  wire logic signed [31:0]                addend,
	input  wire logic [31:0]                       section_base,
	input  wire logic [31:0]                       section_size,
	input  wire logic [31:0]                       place_offset,
	input  wire logic signed [10:0]                plt_index,
	output      logic                              push,
	output      armrel_pkg::item_t                 push_item,
	input  wire logic                              q_full
);
	import armrel_pkg::*;

	localparam logic [31:0] PLT_BYTES = 32'(PLT_SLOT_BYTES * PLT_ENTRIES);

	logic [31:0] code_base_q;
	logic [31:0] code_length_q;
	logic        valid_s1;
	item_t       item_s1;
	item_t       item_c;

	logic [32:0] end_c;
	logic        bad_off_c;
	logic        plt_direct_c;
	logic        addend_pos_c;
	logic [31:0] plt_slot_c;
	logic [31:0] target_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_base_q   <= '0;
			code_length_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CODE_BASE:   code_base_q   <= cfg_data;
				CFG_CODE_LENGTH: code_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		end_c        = {1'b0, place_offset} + 33'd4;
		bad_off_c    = end_c > {1'b0, section_size};
		plt_direct_c = plt_index[10];
		addend_pos_c = !addend[31] && (addend != '0);
		plt_slot_c   = code_base_q + code_length_q - PLT_BYTES
		             + {19'b0, plt_index[9:0], 3'b000} + {20'b0, plt_index[9:0], 2'b00};
		target_c     = plt_direct_c ? symbol_address : plt_slot_c;

		item_c          = '0;
		item_c.old_word = old_word;
		item_c.addend   = $unsigned(addend);
		item_c.opa      = symbol_address;
		item_c.status   = ST_OK;
		unique case (command)
			CMD_ABS32: begin
				item_c.kind = KIND_ABS32;
				item_c.opb  = old_word;
			end
			CMD_CALL, CMD_JMP24: begin
				item_c.kind = KIND_BRANCH;
				item_c.opa  = target_c;
				item_c.opb  = {{6{old_word[23]}}, old_word[23:0], 2'b00};
				item_c.opc  = section_base + place_offset;
				if (!plt_direct_c && addend_pos_c)
					item_c.status = ST_PLT_ADDEND;
			end
			CMD_MOVW: item_c.kind = KIND_MOVW;
			CMD_MOVT: item_c.kind = KIND_MOVT;
			default: begin
				item_c.kind   = KIND_NONE;
				item_c.status = ST_UNKNOWN;
			end
		endcase
		if (item_c.kind != KIND_NONE && bad_off_c)
			item_c.status = ST_BAD_OFFSET;
	end

	assign in_stall  = valid_s1 && q_full;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= item_c;
	end

endmodule

`default_nettype wire

### rtl/armrel_queue.sv
`default_nettype none

module armrel_queue #(
	parameter int unsigned DEPTH = armrel_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire armrel_pkg::item_t push_item,
	output      logic              full,
	input  wire logic              pop,
	output      armrel_pkg::item_t pop_item,
	output      logic              not_empty
);
	import armrel_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t              mem_q [DEPTH];
	item_t              head_q;
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_c;
	logic [CNT_W-1:0]   count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_item  = head_q;

	// read pointer as it stands after this edge
	assign rd_ptr_c = pop ? ((rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1)
	                      : rd_ptr_q;

	// head entry registered; a beat pushed into an emptied queue bypasses the array
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
		if (push && wr_ptr_q == rd_ptr_c)
			head_q <= push_item;
		else
			head_q <= mem_q[rd_ptr_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			rd_ptr_q <= rd_ptr_c;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### rtl/armrel_back.sv
`default_nettype none

module armrel_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              not_empty,
	input  wire armrel_pkg::item_t pop_item,
	output      logic              pop,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic [31:0]       new_word,
	output      logic [2:0]        status
);
	import armrel_pkg::*;

	logic        out_valid_q;
	logic [31:0] new_word_q;
	status_t     status_q;

	logic [31:0] sum_c;
	logic [31:0] mv_c;
	logic        in_range_c;
	logic [31:0] word_c;
	status_t     st_c;

	assign pop = not_empty && (!out_valid_q || !out_stall);

	always_comb begin
		sum_c      = pop_item.opa + pop_item.opb + pop_item.addend - pop_item.opc;
		// value fits in 26 signed bits when bits 31..25 agree
		in_range_c = (sum_c[31:25] == '0) || (sum_c[31:25] == '1);
		mv_c       = (pop_item.kind == KIND_MOVT) ? {16'b0, sum_c[31:16]} : sum_c;
		word_c     = '0;
		st_c       = pop_item.status;
		if (pop_item.status == ST_OK) begin
			unique case (pop_item.kind)
				KIND_BRANCH: begin
					if (in_range_c)
						word_c = (pop_item.old_word & BRANCH_KEEP_MASK) | {8'b0, sum_c[25:2]};
					else
						st_c = ST_RANGE;
				end
				KIND_ABS32: word_c = sum_c;
				KIND_MOVW, KIND_MOVT: begin
					word_c = (pop_item.old_word & MOV_KEEP_MASK)
					       | {12'b0, mv_c[15:12], 16'b0} | (mv_c & MOV_LOW_MASK);
				end
				default: st_c = ST_UNKNOWN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			new_word_q <= word_c;
			status_q   <= st_c;
		end
	end

	assign out_valid = out_valid_q;
	assign new_word  = new_word_q;
	assign status    = status_q;

endmodule

`default_nettype wire

### rtl/arm_relocation_patcher_top.sv
`default_nettype none

// channel   dir  handshake            payload
// cfg       in   cfg_wr_en            cfg_index, cfg_data
// in        in   in_valid/in_stall    command .. plt_index (one relocation)
// out       out  out_valid/out_stall  new_word, status
//
// One relocation per beat in each cycle when out is not stalled.
// A relocation passes the front register, the queue head register and the output register.
// The queue lets the front keep taking beats while out_stall is high
// until it fills; then in_stall rises.
// Reset clears code_base and code_length and all valid/pointer state.

module arm_relocation_patcher_top #(
	parameter int unsigned PLT_ENTRIES = armrel_pkg::PLT_ENTRIES_DEF,
	parameter int unsigned QUEUE_DEPTH = armrel_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [armrel_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                       cfg_data,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic [7:0]                        command,
	input  wire logic [31:0]                       old_word,
	input  wire logic [31:0]                       symbol_address,
	input  wire logic signed [31:0]                addend,
	input  wire logic [31:0]                       section_base,
	input  wire logic [31:0]                       section_size,
	input  wire logic [31:0]                       place_offset,
	input  wire logic signed [10:0]                plt_index,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [31:0]                       new_word,
	output      logic [2:0]                        status
);
	import armrel_pkg::*;

	logic  push;
	item_t push_item;
	logic  q_full;
	logic  pop;
	item_t pop_item;
	logic  not_empty;

	// front: config registers, classification, offset check, target select
	armrel_front #(
		.PLT_ENTRIES(PLT_ENTRIES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.old_word       (old_word),
		.symbol_address (symbol_address),
		.addend         (addend),
		.section_base   (section_base),
		.section_size   (section_size),
		.place_offset   (place_offset),
		.plt_index      (plt_index),
		.push           (push),
		.push_item      (push_item),
		.q_full         (q_full)
	);

	// decouples front from back
	armrel_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (not_empty)
	);

	// back: final add, range check, field packing, output register
	armrel_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.pop_item  (pop_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_word  (new_word),
		.status    (status)
	);

endmodule

`default_nettype wire
